// ===== hw/rtl/udiv64_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udiv64_pkg
// Shared constants and types for the pipelined unsigned divider.
// ----------------------------------------------------------------------------
package udiv64_pkg;

  // width of the operand and result ports
  localparam int unsigned PortWidth = 64;
  // default number of operand bits taken into the division
  localparam int unsigned DataWidth = 64;

  // control that travels alongside each item through the cell chain
  typedef struct packed {
    logic valid;
    logic div_zero;
  } udiv64_ctrl_t;

endpackage

// ===== hw/rtl/udiv64_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udiv64_cell
// One restoring division step: shift in a dividend bit, trial subtract the
// divisor, keep or restore, and register everything for the next cell.
// ----------------------------------------------------------------------------
module udiv64_cell #(
  parameter int unsigned DATA_WIDTH = udiv64_pkg::DataWidth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  udiv64_pkg::udiv64_ctrl_t  ctrl_i,
  input  logic [DATA_WIDTH-1:0]     dividend_i,
  input  logic [DATA_WIDTH-1:0]     divisor_i,
  input  logic [DATA_WIDTH-1:0]     rem_i,
  input  logic [DATA_WIDTH-1:0]     quot_i,
  output udiv64_pkg::udiv64_ctrl_t  ctrl_o,
  output logic [DATA_WIDTH-1:0]     dividend_o,
  output logic [DATA_WIDTH-1:0]     divisor_o,
  output logic [DATA_WIDTH-1:0]     rem_o,
  output logic [DATA_WIDTH-1:0]     quot_o
);
  import udiv64_pkg::*;

  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH+1:0] diff;
  logic                  borrow;

  udiv64_ctrl_t          ctrl_q;
  logic [DATA_WIDTH-1:0] dividend_d, dividend_q;
  logic [DATA_WIDTH-1:0] divisor_q;
  logic [DATA_WIDTH-1:0] rem_d, rem_q;
  logic [DATA_WIDTH-1:0] quot_d, quot_q;

  // partial remainder keeps one extra bit so large divisors still work
  assign shifted = {rem_i, dividend_i[DATA_WIDTH-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor_i};
  assign borrow  = diff[DATA_WIDTH+1];

  always_comb begin
    dividend_d = {dividend_i[DATA_WIDTH-2:0], 1'b0};
    quot_d     = {quot_i[DATA_WIDTH-2:0], ~borrow};
    if (borrow) begin
      rem_d = shifted[DATA_WIDTH-1:0];
    end else begin
      rem_d = diff[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dividend_q <= dividend_d;
    divisor_q  <= divisor_i;
    rem_q      <= rem_d;
    quot_q     <= quot_d;
  end

  assign ctrl_o     = ctrl_q;
  assign dividend_o = dividend_q;
  assign divisor_o  = divisor_q;
  assign rem_o      = rem_q;
  assign quot_o     = quot_q;

endmodule

// ===== hw/rtl/unsigned_divider_64_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsigned_divider_64_core
// Pipelined restoring divider: a chain of DATA_WIDTH cells, one quotient bit
// per cell, giving quotient, remainder and a divide-by-zero flag.
// ----------------------------------------------------------------------------
// each start transfer travels through every cell register of the chain to the done strobe
// throughput: one item per cycle while busy is low, each cell of the chain holds one item
// busy is high only while reset is asserted and the cycle after it
// reset clears the valid flags of the chain; operand registers are not reset
// results are strobed for one cycle; the receiver cannot stall
module unsigned_divider_64_core #(
  parameter int unsigned DATA_WIDTH = udiv64_pkg::DataWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [udiv64_pkg::PortWidth-1:0]  dividend_i,
  input  logic [udiv64_pkg::PortWidth-1:0]  divisor_i,
  output logic                              done_o,
  output logic [udiv64_pkg::PortWidth-1:0]  quotient_o,
  output logic [udiv64_pkg::PortWidth-1:0]  remainder_o,
  output logic                              divide_by_zero_o
);
  import udiv64_pkg::*;

  udiv64_ctrl_t          ctrl_s     [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] dividend_s [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] divisor_s  [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] rem_s      [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] quot_s     [DATA_WIDTH+1];

  logic                  busy_q;
  logic [DATA_WIDTH-1:0] quot_out;
  logic [DATA_WIDTH-1:0] rem_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy = busy_q;

  // head of the chain takes the masked operands straight from the ports
  always_comb begin
    ctrl_s[0].valid    = start & ~busy_q;
    ctrl_s[0].div_zero = (divisor_i[DATA_WIDTH-1:0] == '0);
    dividend_s[0]      = dividend_i[DATA_WIDTH-1:0];
    divisor_s[0]       = divisor_i[DATA_WIDTH-1:0];
    rem_s[0]           = '0;
    quot_s[0]          = '0;
  end

  for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_cell
    udiv64_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl_s[g]),
      .dividend_i (dividend_s[g]),
      .divisor_i  (divisor_s[g]),
      .rem_i      (rem_s[g]),
      .quot_i     (quot_s[g]),
      .ctrl_o     (ctrl_s[g+1]),
      .dividend_o (dividend_s[g+1]),
      .divisor_o  (divisor_s[g+1]),
      .rem_o      (rem_s[g+1]),
      .quot_o     (quot_s[g+1])
    );
  end

  // zero divisor forces both results to zero
  always_comb begin
    if (ctrl_s[DATA_WIDTH].div_zero) begin
      quot_out = '0;
      rem_out  = '0;
    end else begin
      quot_out = quot_s[DATA_WIDTH];
      rem_out  = rem_s[DATA_WIDTH];
    end
  end

  assign done_o           = ctrl_s[DATA_WIDTH].valid;
  assign divide_by_zero_o = ctrl_s[DATA_WIDTH].div_zero;
  assign quotient_o       = PortWidth'(quot_out);
  assign remainder_o      = PortWidth'(rem_out);

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pipelined unsigned divider. A directed set of
// operand corners is followed by random divisions of mixed operand sizes,
// with random gaps between start transfers. Every done strobe is checked
// against an in-order queue of predicted quotient/remainder/error results.
// ----------------------------------------------------------------------------
module tb_top;
  import udiv64_pkg::*;

  localparam int unsigned PW = PortWidth;
  localparam int unsigned DW = DataWidth;
  localparam int unsigned NUM_ITEMS = 850;
  localparam logic [PW-1:0] ALL_ONES = '1;
  localparam logic [PW-1:0] TOP_BIT = {1'b1, {(PW-1){1'b0}}};

  typedef struct packed {
    logic [PW-1:0] dividend;
    logic [PW-1:0] divisor;
  } div_operands_t;

  typedef struct packed {
    logic [PW-1:0] quotient;
    logic [PW-1:0] remainder;
    logic          div_zero;
  } div_result_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [PW-1:0] dividend_i = '0;
  logic [PW-1:0] divisor_i = '0;
  logic          done_o;
  logic [PW-1:0] quotient_o;
  logic [PW-1:0] remainder_o;
  logic          divide_by_zero_o;

  div_operands_t queued_divisions[$];
  div_result_t   awaited_results[$];
  int            gap_left = 0;
  int            transfers_done = 0;
  int            error_count = 0;

  always #1 clk_i = ~clk_i;

  unsigned_divider_64_core #(
    .DATA_WIDTH(DW)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .dividend_i      (dividend_i),
    .divisor_i       (divisor_i),
    .done_o          (done_o),
    .quotient_o      (quotient_o),
    .remainder_o     (remainder_o),
    .divide_by_zero_o(divide_by_zero_o)
  );

  // restoring division with a one-bit-wider partial remainder
  function automatic div_result_t divide_u64(input logic [PW-1:0] num,
                                             input logic [PW-1:0] den);
    logic [PW-1:0] mask;
    logic [PW-1:0] n;
    logic [PW-1:0] d;
    logic [PW:0]   part;
    div_result_t   res;
    mask = ALL_ONES >> (PW - DW);
    n = num & mask;
    d = den & mask;
    res = '0;
    if (d == '0) begin
      res.div_zero = 1'b1;
      return res;
    end
    part = '0;
    for (int i = DW - 1; i >= 0; i--) begin
      part = {part[PW-1:0], n[i]};
      if (part >= {1'b0, d}) begin
        part = part - {1'b0, d};
        res.quotient[i] = 1'b1;
      end
    end
    res.quotient = res.quotient & mask;
    res.remainder = part[PW-1:0] & mask;
    return res;
  endfunction

  function automatic logic [PW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // random value of random bit length
  function automatic logic [PW-1:0] rand_sized();
    return rand_word() >> $urandom_range(0, PW - 1);
  endfunction

  function automatic div_operands_t rand_division();
    div_operands_t ops;
    int            pick;
    pick = $urandom_range(0, 99);
    ops.dividend = rand_word();
    if (pick < 35) begin
      ops.divisor = rand_word();
    end else if (pick < 65) begin
      ops.divisor = rand_sized();
    end else if (pick < 78) begin
      ops.dividend = rand_sized();
      ops.divisor = rand_sized();
    end else if (pick < 84) begin
      ops.divisor = '0;
    end else if (pick < 91) begin
      ops.divisor = {{(PW-1){1'b0}}, 1'b1} << $urandom_range(0, PW - 1);
    end else if (pick < 96) begin
      // divisor within two of the dividend, so the quotient is usually zero or one
      ops.divisor = ops.dividend + PW'($urandom_range(0, 4)) - PW'(2);
    end else begin
      // exact multiple plus a small offset
      ops.divisor = rand_sized();
      ops.dividend = ops.divisor * PW'($urandom_range(1, 1000)) + PW'($urandom_range(0, 3));
    end
    return ops;
  endfunction

  // mostly short gaps, a few long ones, and back-to-back bursts
  function automatic int pick_gap(input int sent);
    int r;
    if ((sent % 200) < 40) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver
  always @(posedge clk_i) begin : drive_start
    div_operands_t ops;
    int            idle;
    if (rst_ni) begin
      idle = gap_left;
      if (start && !busy) begin
        awaited_results.push_back(divide_u64(dividend_i, divisor_i));
        transfers_done <= transfers_done + 1;
        idle = pick_gap(transfers_done);
      end
      if (!start || !busy) begin
        if (idle == 0 && queued_divisions.size() > 0) begin
          ops = queued_divisions.pop_front();
          start <= 1'b1;
          dividend_i <= ops.dividend;
          divisor_i <= ops.divisor;
          gap_left <= 0;
        end else begin
          // junk on the operand ports while start is low
          start <= 1'b0;
          dividend_i <= rand_word();
          divisor_i <= rand_word();
          gap_left <= (idle > 0) ? idle - 1 : 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : check_results
    div_result_t exp;
    if (rst_ni && done_o) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result q=%h r=%h dbz=%b", $time, quotient_o,
                 remainder_o, divide_by_zero_o);
        error_count++;
      end else begin
        exp = awaited_results.pop_front();
        if (quotient_o !== exp.quotient) begin
          $display("%0t: quotient expected %h actual %h", $time, exp.quotient,
                   quotient_o);
          error_count++;
        end
        if (remainder_o !== exp.remainder) begin
          $display("%0t: remainder expected %h actual %h", $time, exp.remainder,
                   remainder_o);
          error_count++;
        end
        if (divide_by_zero_o !== exp.div_zero) begin
          $display("%0t: divide_by_zero expected %b actual %b", $time, exp.div_zero,
                   divide_by_zero_o);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    div_operands_t directed[$];
    int            drain;
    directed.push_back('{'0, 64'd1});
    directed.push_back('{'0, '0});
    directed.push_back('{ALL_ONES, '0});
    directed.push_back('{64'd1234, '0});
    directed.push_back('{ALL_ONES, 64'd1});
    directed.push_back('{ALL_ONES, ALL_ONES});
    directed.push_back('{ALL_ONES - 64'd1, ALL_ONES});
    directed.push_back('{64'd1, ALL_ONES});
    directed.push_back('{ALL_ONES, TOP_BIT});
    directed.push_back('{ALL_ONES, TOP_BIT + 64'd1});
    directed.push_back('{TOP_BIT, TOP_BIT + 64'd1});
    directed.push_back('{TOP_BIT, TOP_BIT});
    directed.push_back('{TOP_BIT, 64'd3});
    directed.push_back('{ALL_ONES, 64'd2});
    directed.push_back('{ALL_ONES, 64'hFFFF_FFFF});
    directed.push_back('{ALL_ONES, 64'h1_0000_0000});
    directed.push_back('{ALL_ONES, 64'hFFFF_FFFF_0000_0001});
    directed.push_back('{64'd100, 64'd7});
    directed.push_back('{64'd7, 64'd100});
    directed.push_back('{64'hFFFF_FFFF, 64'hFFFF_FFFF});
    directed.push_back('{64'd42, 64'd42});
    directed.push_back('{64'hDEAD_BEEF_CAFE_F00D, 64'h10});
    directed.push_back('{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA});
    foreach (directed[i]) queued_divisions.push_back(directed[i]);
    while (queued_divisions.size() < NUM_ITEMS) queued_divisions.push_back(rand_division());

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (transfers_done < NUM_ITEMS) @(posedge clk_i);
    while (awaited_results.size() > 0) @(posedge clk_i);
    // let any stray strobes from the pipeline show up
    for (drain = 0; drain < DW + 16; drain++) @(posedge clk_i);

    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== unsigned_divider_64_core.f =====
hw/rtl/udiv64_pkg.sv
hw/rtl/udiv64_cell.sv
hw/rtl/unsigned_divider_64_core.sv
verif/tb_top.sv
